FILE: design/ncb_pkg.sv
`timescale 1ns / 1ps
package ncb_pkg;

  localparam int COORD_BITS = 16;
  // internal coordinate width: holds every sum and difference of the slicing and clip math
  localparam int CW = 20;
  localparam int NUM_W = 33;
  localparam int DEN_W = 15;
  localparam int DIV_LAT = NUM_W;

  localparam logic [3:0] PIECE_CENTER = 4'd8;

  localparam logic [1:0] SLICE_NEAR = 2'd0;
  localparam logic [1:0] SLICE_FAR = 2'd1;
  localparam logic [1:0] SLICE_MID = 2'd2;

  typedef enum logic [2:0] {
    REG_BORDER_LEFT   = 3'd0,
    REG_BORDER_RIGHT  = 3'd1,
    REG_BORDER_TOP    = 3'd2,
    REG_BORDER_BOTTOM = 3'd3,
    REG_BORDER_SCALE  = 3'd4,
    REG_CLIP_ENABLE   = 3'd5,
    REG_CLIP_ORIGIN   = 3'd6,
    REG_CLIP_SIZE     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic [14:0] dst_w;
    logic [14:0] dst_h;
    logic [14:0] tex_x;
    logic [14:0] tex_y;
    logic [14:0] tex_w;
    logic [14:0] tex_h;
  } in_item_t;

  typedef struct packed {
    logic [3:0] piece;
    logic last;
    logic signed [15:0] src_x;
    logic signed [15:0] src_y;
    logic signed [15:0] src_w;
    logic signed [15:0] src_h;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_w;
    logic signed [15:0] out_h;
  } out_item_t;

  typedef struct packed {
    logic [7:0] bl;
    logic [7:0] br;
    logic [7:0] bt;
    logic [7:0] bb;
    logic [3:0] scale;
    logic clip_en;
    logic signed [15:0] clip_x;
    logic signed [15:0] clip_y;
    logic [15:0] clip_w;
    logic [15:0] clip_h;
  } cfg_t;

  typedef struct packed {
    logic [3:0] piece;
    logic last;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] sw;
    logic signed [CW-1:0] sh;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] dw;
    logic signed [CW-1:0] dh;
  } rect_t;

  typedef struct packed {
    logic signed [CW-1:0] dpos;
    logic signed [CW-1:0] dlen;
    logic signed [CW-1:0] sbase;
    logic signed [CW-1:0] slen;
    logic use_div;
    logic nl_neg;
    logic off_neg;
  } axis_t;

  typedef struct packed {
    logic [3:0] piece;
    logic last;
    axis_t ax;
    axis_t ay;
  } side_t;

  function automatic logic [1:0] piece_col(input logic [3:0] p);
    case (p)
      4'd0, 4'd2, 4'd4: piece_col = SLICE_NEAR;
      4'd1, 4'd3, 4'd5: piece_col = SLICE_FAR;
      default: piece_col = SLICE_MID;
    endcase
  endfunction

  function automatic logic [1:0] piece_row(input logic [3:0] p);
    case (p)
      4'd0, 4'd1, 4'd6: piece_row = SLICE_NEAR;
      4'd2, 4'd3, 4'd7: piece_row = SLICE_FAR;
      default: piece_row = SLICE_MID;
    endcase
  endfunction

  // wrap to COORD_BITS two's complement, then take the 16-bit field
  function automatic logic signed [15:0] wrap_coord(input logic signed [39:0] v);
    logic signed [39:0] t;
    t = (v <<< (40 - COORD_BITS)) >>> (40 - COORD_BITS);
    wrap_coord = t[15:0];
  endfunction

endpackage

FILE: design/ncb_div.sv
`timescale 1ns / 1ps
module ncb_div (
  input  logic clk,
  input  logic [ncb_pkg::NUM_W-1:0] num,
  input  logic [ncb_pkg::DEN_W-1:0] den,
  output logic [ncb_pkg::NUM_W-1:0] quo
);
  import ncb_pkg::*;

  logic [NUM_W-1:0] num_s [0:NUM_W];
  logic [NUM_W-1:0] quo_s [0:NUM_W];
  logic [DEN_W-1:0] rem_s [0:NUM_W];
  logic [DEN_W-1:0] den_s [0:NUM_W];

  assign num_s[0] = num;
  assign quo_s[0] = '0;
  assign rem_s[0] = '0;
  assign den_s[0] = den;

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic ge;
    always_comb begin
      trial = {rem_s[k], num_s[k][NUM_W-1]};
      diff = trial - {1'b0, den_s[k]};
      ge = trial >= {1'b0, den_s[k]};
    end
    always_ff @(posedge clk) begin
      rem_s[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_s[k+1] <= {num_s[k][NUM_W-2:0], 1'b0};
      quo_s[k+1] <= {quo_s[k][NUM_W-2:0], ge};
      den_s[k+1] <= den_s[k];
    end
  end

  assign quo = quo_s[NUM_W];

endmodule

FILE: design/ncb_seq.sv
`timescale 1ns / 1ps
module ncb_seq (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  ncb_pkg::in_item_t item,
  input  ncb_pkg::cfg_t cfg,
  output logic rect_valid,
  output ncb_pkg::rect_t rect
);
  import ncb_pkg::*;

  logic active;
  logic [3:0] p;
  in_item_t hold;
  logic accept;
  logic single;

  logic [1:0] col;
  logic [1:0] row;
  logic signed [CW-1:0] x, y, w, h, tx, ty, tw, th;
  logic signed [CW-1:0] bl, br, bt, bb, bls, brs, bts, bbs;
  rect_t rect_next;

  assign single = (cfg.bl == '0) && (cfg.br == '0) && (cfg.bt == '0) && (cfg.bb == '0);
  assign busy = active && (p != PIECE_CENTER);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      p <= '0;
    end else if (accept) begin
      active <= 1'b1;
      p <= single ? PIECE_CENTER : 4'd0;
    end else if (active) begin
      if (p == PIECE_CENTER) begin
        active <= 1'b0;
      end else begin
        p <= p + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= item;
    end
  end

  always_comb begin
    x = CW'(hold.dst_x);
    y = CW'(hold.dst_y);
    w = CW'(hold.dst_w);
    h = CW'(hold.dst_h);
    tx = CW'(hold.tex_x);
    ty = CW'(hold.tex_y);
    tw = CW'(hold.tex_w);
    th = CW'(hold.tex_h);
    bl = CW'(cfg.bl);
    br = CW'(cfg.br);
    bt = CW'(cfg.bt);
    bb = CW'(cfg.bb);
    bls = CW'(cfg.bl * cfg.scale);
    brs = CW'(cfg.br * cfg.scale);
    bts = CW'(cfg.bt * cfg.scale);
    bbs = CW'(cfg.bb * cfg.scale);
    col = piece_col(p);
    row = piece_row(p);
    rect_next.piece = p;
    rect_next.last = (p == PIECE_CENTER);
    case (col)
      SLICE_NEAR: begin
        rect_next.sx = tx;
        rect_next.sw = bl;
        rect_next.dx = x;
        rect_next.dw = bls;
      end
      SLICE_FAR: begin
        rect_next.sx = tx + tw - br;
        rect_next.sw = br;
        rect_next.dx = x + w - brs;
        rect_next.dw = brs;
      end
      default: begin
        rect_next.sx = tx + bl;
        rect_next.sw = tw - bl - br;
        rect_next.dx = x + bls;
        rect_next.dw = w - bls - brs;
      end
    endcase
    case (row)
      SLICE_NEAR: begin
        rect_next.sy = ty;
        rect_next.sh = bt;
        rect_next.dy = y;
        rect_next.dh = bts;
      end
      SLICE_FAR: begin
        rect_next.sy = ty + th - bb;
        rect_next.sh = bb;
        rect_next.dy = y + h - bbs;
        rect_next.dh = bbs;
      end
      default: begin
        rect_next.sy = ty + bt;
        rect_next.sh = th - bt - bb;
        rect_next.dy = y + bts;
        rect_next.dh = h - bts - bbs;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_valid <= 1'b0;
    end else begin
      rect_valid <= active;
    end
    rect <= rect_next;
  end

  a_busy_active: assert property (@(posedge clk) disable iff (rst) busy |-> active)
    else $error("busy without an item in progress");
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> active && (p == 4'd0 || p == PIECE_CENTER))
    else $error("new item does not start at first or center piece");
  a_advance: assert property (@(posedge clk) disable iff (rst)
    active && (p != PIECE_CENTER) |=> active && (p == $past(p) + 4'd1))
    else $error("piece counter skipped");
  a_issue: assert property (@(posedge clk) disable iff (rst) active |=> rect_valid)
    else $error("piece issued without valid");

endmodule

FILE: design/ncb_clip.sv
`timescale 1ns / 1ps
module ncb_clip (
  input  logic clk,
  input  logic rst,
  input  ncb_pkg::cfg_t cfg,
  input  logic rect_valid,
  input  ncb_pkg::rect_t rect,
  output logic side_valid,
  output ncb_pkg::side_t side,
  output logic [ncb_pkg::NUM_W-1:0] nl_x,
  output logic [ncb_pkg::NUM_W-1:0] off_x,
  output logic [ncb_pkg::NUM_W-1:0] nl_y,
  output logic [ncb_pkg::NUM_W-1:0] off_y,
  output logic [ncb_pkg::DEN_W-1:0] den_x,
  output logic [ncb_pkg::DEN_W-1:0] den_y
);
  import ncb_pkg::*;

  typedef struct packed {
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] len;
    logic signed [CW-1:0] rel;
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] sl;
    logic signed [CW-1:0] d;
    logic signed [CW-1:0] dl;
  } clip_ax_t;

  function automatic clip_ax_t clip_calc(input logic signed [CW-1:0] d,
                                         input logic signed [CW-1:0] dl,
                                         input logic signed [CW-1:0] s,
                                         input logic signed [CW-1:0] sl,
                                         input logic signed [CW-1:0] c,
                                         input logic signed [CW-1:0] cl);
    clip_ax_t r;
    logic signed [CW-1:0] e1;
    logic signed [CW-1:0] e2;
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] diff;
    r.lo = (d > c) ? d : c;
    e1 = d + dl;
    e2 = c + cl;
    hi = (e1 < e2) ? e1 : e2;
    diff = hi - r.lo;
    r.len = (diff > 0) ? diff : '0;
    r.rel = r.lo - d;
    r.s = s;
    r.sl = sl;
    r.d = d;
    r.dl = dl;
    clip_calc = r;
  endfunction

  // stage 2: intersect with the clip window
  logic s2_valid;
  logic [3:0] s2_piece;
  logic s2_last;
  clip_ax_t s2_x, s2_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= rect_valid;
    end
    s2_piece <= rect.piece;
    s2_last <= rect.last;
    s2_x <= clip_calc(rect.dx, rect.dw, rect.sx, rect.sw, CW'(cfg.clip_x), CW'(cfg.clip_w));
    s2_y <= clip_calc(rect.dy, rect.dh, rect.sy, rect.sh, CW'(cfg.clip_y), CW'(cfg.clip_h));
  end

  // stage 3: scale source by the kept fraction, split sign for the divider
  logic signed [2*CW-1:0] pn_x, po_x, pn_y, po_y;
  logic signed [2*CW-1:0] mn_x, mo_x, mn_y, mo_y;
  side_t side_next;

  function automatic axis_t side_ax(input clip_ax_t a, input logic en,
                                    input logic nn, input logic on);
    axis_t r;
    r.use_div = en && (a.dl > 0);
    r.dpos = en ? a.lo : a.d;
    r.dlen = en ? a.len : a.dl;
    r.sbase = a.s;
    r.slen = en ? '0 : a.sl;
    r.nl_neg = nn;
    r.off_neg = on;
    side_ax = r;
  endfunction

  always_comb begin
    pn_x = s2_x.len * s2_x.sl;
    po_x = s2_x.rel * s2_x.sl;
    pn_y = s2_y.len * s2_y.sl;
    po_y = s2_y.rel * s2_y.sl;
    mn_x = (pn_x < 0) ? -pn_x : pn_x;
    mo_x = (po_x < 0) ? -po_x : po_x;
    mn_y = (pn_y < 0) ? -pn_y : pn_y;
    mo_y = (po_y < 0) ? -po_y : po_y;
    side_next.piece = s2_piece;
    side_next.last = s2_last;
    side_next.ax = side_ax(s2_x, cfg.clip_en, pn_x < 0, po_x < 0);
    side_next.ay = side_ax(s2_y, cfg.clip_en, pn_y < 0, po_y < 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_valid <= 1'b0;
    end else begin
      side_valid <= s2_valid;
    end
    side <= side_next;
    nl_x <= mn_x[NUM_W-1:0];
    off_x <= mo_x[NUM_W-1:0];
    nl_y <= mn_y[NUM_W-1:0];
    off_y <= mo_y[NUM_W-1:0];
    den_x <= (s2_x.dl > 0) ? s2_x.dl[DEN_W-1:0] : DEN_W'(1);
    den_y <= (s2_y.dl > 0) ? s2_y.dl[DEN_W-1:0] : DEN_W'(1);
  end

endmodule

FILE: design/nine_slice_clip_blit.sv
`timescale 1ns / 1ps
// Nine-slice blit command generator with clip. An item (destination and texture
// rectangles) is taken when start is high and busy is low; it yields nine words
// (corners, edges, center) or one center word when all borders are zero, one word
// per cycle on result with result_valid high for that single cycle, so a new item
// can be taken as soon as the center piece of the last one is issued. The
// one-word-per-cycle piece sequencer sets the item rate. Each word passes
// through slicing, clip, multiply, a 33-stage one-bit-per-stage divider for the
// proportional source shrink, and the output register. Results cannot be held
// off. Configuration is written through cfg_valid/cfg_index/cfg_data (always
// ready), by the user only while no item is in flight; the block does not check.
module nine_slice_clip_blit (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  ncb_pkg::in_item_t item,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  output logic result_valid,
  output ncb_pkg::out_item_t result
);
  import ncb_pkg::*;

  cfg_t cfg;
  logic rect_valid;
  rect_t rect;
  logic side_valid;
  side_t side;
  logic [NUM_W-1:0] nl_x, off_x, nl_y, off_y;
  logic [NUM_W-1:0] qn_x, qo_x, qn_y, qo_y;
  logic [DEN_W-1:0] den_x, den_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bl <= '0;
      cfg.br <= '0;
      cfg.bt <= '0;
      cfg.bb <= '0;
      cfg.scale <= 4'd1;
      cfg.clip_en <= 1'b0;
      cfg.clip_x <= '0;
      cfg.clip_y <= '0;
      cfg.clip_w <= '0;
      cfg.clip_h <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_e'(cfg_index))
        REG_BORDER_LEFT: cfg.bl <= cfg_data[7:0];
        REG_BORDER_RIGHT: cfg.br <= cfg_data[7:0];
        REG_BORDER_TOP: cfg.bt <= cfg_data[7:0];
        REG_BORDER_BOTTOM: cfg.bb <= cfg_data[7:0];
        REG_BORDER_SCALE: cfg.scale <= cfg_data[3:0];
        REG_CLIP_ENABLE: cfg.clip_en <= cfg_data[0];
        REG_CLIP_ORIGIN: begin
          cfg.clip_x <= cfg_data[15:0];
          cfg.clip_y <= cfg_data[31:16];
        end
        REG_CLIP_SIZE: begin
          cfg.clip_w <= cfg_data[15:0];
          cfg.clip_h <= cfg_data[31:16];
        end
        default: ;
      endcase
    end
  end

  ncb_seq u_seq (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item), .cfg(cfg),
    .rect_valid(rect_valid), .rect(rect)
  );

  ncb_clip u_clip (
    .clk(clk), .rst(rst), .cfg(cfg), .rect_valid(rect_valid), .rect(rect),
    .side_valid(side_valid), .side(side),
    .nl_x(nl_x), .off_x(off_x), .nl_y(nl_y), .off_y(off_y),
    .den_x(den_x), .den_y(den_y)
  );

  ncb_div u_div_nx (.clk(clk), .num(nl_x), .den(den_x), .quo(qn_x));
  ncb_div u_div_ox (.clk(clk), .num(off_x), .den(den_x), .quo(qo_x));
  ncb_div u_div_ny (.clk(clk), .num(nl_y), .den(den_y), .quo(qn_y));
  ncb_div u_div_oy (.clk(clk), .num(off_y), .den(den_y), .quo(qo_y));

  // carry the side data alongside the dividers
  side_t side_d [0:DIV_LAT];
  logic [DIV_LAT:0] vld_d;

  assign side_d[0] = side;
  assign vld_d[0] = side_valid;

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_delay
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_d[k+1] <= 1'b0;
      end else begin
        vld_d[k+1] <= vld_d[k];
      end
      side_d[k+1] <= side_d[k];
    end
  end

  function automatic logic signed [39:0] apply_sign(input logic [NUM_W-1:0] q,
                                                    input logic neg);
    logic signed [39:0] v;
    v = 40'(q);
    apply_sign = neg ? -v : v;
  endfunction

  side_t sf;
  logic signed [39:0] src_px, src_lx, src_py, src_ly;
  out_item_t result_next;

  always_comb begin
    sf = side_d[DIV_LAT];
    src_px = 40'(sf.ax.sbase);
    src_lx = 40'(sf.ax.slen);
    src_py = 40'(sf.ay.sbase);
    src_ly = 40'(sf.ay.slen);
    if (sf.ax.use_div) begin
      src_px = 40'(sf.ax.sbase) + apply_sign(qo_x, sf.ax.off_neg);
      src_lx = apply_sign(qn_x, sf.ax.nl_neg);
    end
    if (sf.ay.use_div) begin
      src_py = 40'(sf.ay.sbase) + apply_sign(qo_y, sf.ay.off_neg);
      src_ly = apply_sign(qn_y, sf.ay.nl_neg);
    end
    result_next.piece = sf.piece;
    result_next.last = sf.last;
    result_next.src_x = wrap_coord(src_px);
    result_next.src_y = wrap_coord(src_py);
    result_next.src_w = wrap_coord(src_lx);
    result_next.src_h = wrap_coord(src_ly);
    result_next.out_x = wrap_coord(40'(sf.ax.dpos));
    result_next.out_y = wrap_coord(40'(sf.ay.dpos));
    result_next.out_w = wrap_coord(40'(sf.ax.dlen));
    result_next.out_h = wrap_coord(40'(sf.ay.dlen));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= vld_d[DIV_LAT];
    end
    result <= result_next;
  end

endmodule
